/* rtl/core/nbgfe_pkg.sv */
package nbgfe_pkg;

    localparam int MAX_BODIES = 1024;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);
    localparam int ID_W       = 10;
    localparam int CMP_W      = (CNT_W > ID_W + 1) ? CNT_W : ID_W + 1;

    // pair terms stay below 2^97, so this never wraps
    localparam int ACC_W      = 100 + 2 * CNT_W;
    localparam int NUM_W      = 97;
    localparam int DIV_W      = 66;
    localparam int REM_W      = 67;
    localparam int CNT_STEP_W = 7;

    localparam logic [CNT_STEP_W-1:0] DIV_STEPS  = CNT_STEP_W'(NUM_W);
    localparam logic [CNT_STEP_W-1:0] SQRT_STEPS = CNT_STEP_W'(DIV_W / 2);

    localparam int IN_DATA_W  = 240;
    localparam int OUT_DATA_W = 256;

    localparam logic [1:0] FN_APPEND    = 2'd0;
    localparam logic [1:0] FN_FORCE     = 2'd1;
    localparam logic [1:0] FN_POTENTIAL = 2'd2;
    localparam logic [1:0] FN_KINETIC   = 2'd3;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_NOIDX = 2'd2;

    localparam logic [1:0] REG_GRAV    = 2'd0;
    localparam logic [1:0] REG_MIN_DSQ = 2'd1;
    localparam logic [1:0] REG_MIN_D   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_QWT, ST_QLD, ST_JSEL, ST_JWT, ST_DIF, ST_SQ, ST_CLAMP,
        ST_SQRT, ST_RFIX, ST_K1, ST_K2, ST_K3, ST_CSEL, ST_UDIV, ST_P1,
        ST_P2, ST_P3, ST_MDIV, ST_ISEL, ST_IWT, ST_ILD, ST_KSEL, ST_KWT,
        ST_KV, ST_KM1, ST_KM2, ST_KACC, ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] vel_z;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } body_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {a[31], a} + {b[31], b};
        if (sum[32] != sum[31]) begin
            sat_add32 = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sat_add32 = sum[31:0];
        end
    endfunction

    function automatic logic [63:0] sat64(input logic [ACC_W-1:0] a);
        logic [ACC_W-64:0] hi;
        hi = a[ACC_W-1:63];
        if ((&hi) || !(|hi)) begin
            sat64 = a[63:0];
        end else if (a[ACC_W-1]) begin
            sat64 = 64'h8000_0000_0000_0000;
        end else begin
            sat64 = 64'h7FFF_FFFF_FFFF_FFFF;
        end
    endfunction

endpackage

/* rtl/core/nbody_gravity_force_energy_unit.sv */
// channel   dir  signals                                   contents
// s_        in   s_tvalid s_tready s_tdata s_tuser        one command item
// m_        out  m_tvalid m_tready m_tdata m_tuser        one result item
// cfg_      in   cfg_valid cfg_ready cfg_index cfg_data   register write
//
// division and square root share one restoring divide/sqrt unit: 97 steps per
// division, 33 per square root, one bit per cycle, beside one 32x32 multiplier.
// aresetn is synchronous: body count cleared, registers to 1; the table is not cleared.
// s_tready is high only when idle; a finished result waits in the output register.
module nbody_gravity_force_energy_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // body_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass, zero pad
    input  logic [nbgfe_pkg::IN_DATA_W-1:0]     s_tdata,
    // func
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_x, out_y, out_z, out_energy
    output logic [nbgfe_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [31:0]                         cfg_data
);

    localparam int ACC_W = nbgfe_pkg::ACC_W;
    localparam int NUM_W = nbgfe_pkg::NUM_W;
    localparam int REM_W = nbgfe_pkg::REM_W;
    localparam int DIV_W = nbgfe_pkg::DIV_W;
    localparam int CNT_W = nbgfe_pkg::CNT_W;
    localparam int IDX_W = nbgfe_pkg::IDX_W;
    localparam int CMP_W = nbgfe_pkg::CMP_W;
    localparam int SW    = nbgfe_pkg::CNT_STEP_W;

    nbgfe_pkg::state_t state_reg, state_next;

    logic [1:0]         func_reg, func_next;
    logic [9:0]         id_reg, id_next;
    logic [31:0]        off_reg [3];
    logic [31:0]        off_next [3];
    logic [CNT_W-1:0]   n_reg, n_next, i_reg, i_next, j_reg, j_next;
    logic [IDX_W-1:0]   addr_reg, addr_next;
    logic [31:0]        bp_reg [3];
    logic [31:0]        bp_next [3];
    logic [31:0]        bm_reg, bm_next;
    logic signed [32:0] d_reg [3];
    logic signed [32:0] d_next [3];
    logic [1:0]         comp_reg, comp_next;
    logic [NUM_W-1:0]   prod_reg, prod_next;
    logic [DIV_W-1:0]   s_reg, s_next;
    logic [32:0]        r_reg, r_next;
    logic [63:0]        k_reg, k_next;
    logic [32:0]        u_reg, u_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [SW-1:0]      cnt_reg, cnt_next;
    logic [ACC_W-1:0]   acc_reg [4];
    logic [ACC_W-1:0]   acc_next [4];
    logic [1:0]         status_reg, status_next;
    logic [31:0]        grav_reg, mdsq_reg, md_reg;
    logic               m_valid_reg, m_valid_next;
    logic [nbgfe_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [1:0]         m_user_reg, m_user_next;

    nbgfe_pkg::body_t   mem [nbgfe_pkg::MAX_BODIES];
    nbgfe_pkg::body_t   rd_reg;
    nbgfe_pkg::body_t   wr_body;
    logic               mem_we;

    logic [31:0]        rd_pos [3];
    logic signed [32:0] d_sel;
    logic [32:0]        d_abs;
    logic [31:0]        dmag;
    logic [31:0]        vsel, vmag;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic [REM_W-1:0]   sub_a, sub_b;
    logic [REM_W:0]     diff;
    logic               ge;
    logic [REM_W-1:0]   rem_step;
    logic [NUM_W-1:0]   num_step;
    logic [DIV_W-1:0]   divisor;
    logic [DIV_W-1:0]   s_c;
    logic [32:0]        r_fix;
    logic [NUM_W-1:0]   p_fin;
    logic [ACC_W-1:0]   q_ext;
    logic               step_last;

    assign s_tready  = (state_reg == nbgfe_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign wr_body.pos_x = s_tdata[41:10];
    assign wr_body.pos_y = s_tdata[73:42];
    assign wr_body.pos_z = s_tdata[105:74];
    assign wr_body.vel_x = s_tdata[137:106];
    assign wr_body.vel_y = s_tdata[169:138];
    assign wr_body.vel_z = s_tdata[201:170];
    assign wr_body.mass  = s_tdata[233:202];

    assign rd_pos[0] = rd_reg.pos_x;
    assign rd_pos[1] = rd_reg.pos_y;
    assign rd_pos[2] = rd_reg.pos_z;

    always_comb begin
        d_sel = d_reg[comp_reg];
        d_abs = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
        dmag  = d_abs[31:0];
        unique case (comp_reg)
            2'd0:    vsel = rd_reg.vel_x;
            2'd1:    vsel = rd_reg.vel_y;
            default: vsel = rd_reg.vel_z;
        endcase
        vmag = vsel[31] ? (32'd0 - vsel) : vsel;
    end

    // the one multiplier
    always_comb begin
        mul_a = dmag;
        mul_b = dmag;
        unique case (state_reg)
            nbgfe_pkg::ST_K1: begin
                mul_a = bm_reg;
                mul_b = rd_reg.mass;
            end
            nbgfe_pkg::ST_K2: begin
                mul_a = grav_reg;
                mul_b = k_reg[31:0];
            end
            nbgfe_pkg::ST_K3: begin
                mul_a = grav_reg;
                mul_b = k_reg[63:32];
            end
            nbgfe_pkg::ST_P1: begin
                mul_a = k_reg[31:0];
                mul_b = u_reg[31:0];
            end
            nbgfe_pkg::ST_P2: begin
                mul_a = k_reg[63:32];
                mul_b = u_reg[31:0];
            end
            nbgfe_pkg::ST_KV: begin
                mul_a = vmag;
                mul_b = vmag;
            end
            nbgfe_pkg::ST_KM1: begin
                mul_a = rd_reg.mass;
                mul_b = prod_reg[31:0];
            end
            nbgfe_pkg::ST_KM2: begin
                mul_a = rd_reg.mass;
                mul_b = k_reg[63:32];
            end
            default: begin
                mul_a = dmag;
                mul_b = dmag;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // the one subtractor, shared by square root and division steps
    always_comb begin
        if (state_reg == nbgfe_pkg::ST_UDIV ||
            (state_reg == nbgfe_pkg::ST_MDIV && func_reg == nbgfe_pkg::FN_POTENTIAL)) begin
            divisor = DIV_W'(r_reg);
        end else begin
            divisor = s_reg;
        end
        if (state_reg == nbgfe_pkg::ST_SQRT) begin
            sub_a    = {rem_reg[REM_W-3:0], num_reg[NUM_W-1:NUM_W-2]};
            sub_b    = REM_W'({r_reg, 2'b01});
        end else begin
            sub_a    = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
            sub_b    = REM_W'(divisor);
        end
        diff     = {1'b0, sub_a} - {1'b0, sub_b};
        ge       = ~diff[REM_W];
        rem_step = ge ? diff[REM_W-1:0] : sub_a;
        if (state_reg == nbgfe_pkg::ST_SQRT) begin
            num_step = {num_reg[NUM_W-3:0], 2'b00};
        end else begin
            num_step = {num_reg[NUM_W-2:0], ge};
        end
        step_last = (cnt_reg == SW'(1));
    end

    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        id_next     = id_reg;
        off_next    = off_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        addr_next   = addr_reg;
        bp_next     = bp_reg;
        bm_next     = bm_reg;
        d_next      = d_reg;
        comp_next   = comp_reg;
        prod_next   = prod_reg;
        s_next      = s_reg;
        r_next      = r_reg;
        k_next      = k_reg;
        u_next      = u_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        status_next = status_reg;
        m_data_next = m_data_reg;
        m_user_next = m_user_reg;
        m_valid_next = m_valid_reg && !m_tready;
        mem_we      = 1'b0;
        s_c         = prod_reg[DIV_W-1:0];
        r_fix       = r_reg;
        p_fin       = prod_reg;
        q_ext       = ACC_W'(num_step);

        unique case (state_reg)
            nbgfe_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    func_next   = s_tuser;
                    id_next     = s_tdata[9:0];
                    off_next[0] = wr_body.pos_x;
                    off_next[1] = wr_body.pos_y;
                    off_next[2] = wr_body.pos_z;
                    for (int e = 0; e < 4; e++) begin
                        acc_next[e] = '0;
                    end
                    status_next = nbgfe_pkg::STS_OK;
                    i_next      = '0;
                    unique case (s_tuser)
                        nbgfe_pkg::FN_APPEND: begin
                            if (n_reg < CNT_W'(nbgfe_pkg::MAX_BODIES)) begin
                                mem_we = 1'b1;
                                n_next = n_reg + CNT_W'(1);
                            end else begin
                                status_next = nbgfe_pkg::STS_FULL;
                            end
                            state_next = nbgfe_pkg::ST_DONE;
                        end
                        nbgfe_pkg::FN_FORCE: begin
                            if (CMP_W'(s_tdata[9:0]) >= CMP_W'(n_reg)) begin
                                status_next = nbgfe_pkg::STS_NOIDX;
                                state_next  = nbgfe_pkg::ST_DONE;
                            end else begin
                                addr_next  = IDX_W'(s_tdata[9:0]);
                                state_next = nbgfe_pkg::ST_QWT;
                            end
                        end
                        nbgfe_pkg::FN_POTENTIAL: state_next = nbgfe_pkg::ST_ISEL;
                        nbgfe_pkg::FN_KINETIC:   state_next = nbgfe_pkg::ST_KSEL;
                    endcase
                end
            end
            nbgfe_pkg::ST_QWT: state_next = nbgfe_pkg::ST_QLD;
            nbgfe_pkg::ST_QLD: begin
                for (int c = 0; c < 3; c++) begin
                    bp_next[c] = nbgfe_pkg::sat_add32(rd_pos[c], off_reg[c]);
                end
                bm_next    = rd_reg.mass;
                j_next     = '0;
                state_next = nbgfe_pkg::ST_JSEL;
            end
            nbgfe_pkg::ST_JSEL: begin
                if (j_reg == n_reg) begin
                    if (func_reg == nbgfe_pkg::FN_FORCE) begin
                        state_next = nbgfe_pkg::ST_DONE;
                    end else begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = nbgfe_pkg::ST_ISEL;
                    end
                end else if (func_reg == nbgfe_pkg::FN_FORCE &&
                             CMP_W'(j_reg) == CMP_W'(id_reg)) begin
                    j_next = j_reg + CNT_W'(1);
                end else begin
                    addr_next  = j_reg[IDX_W-1:0];
                    state_next = nbgfe_pkg::ST_JWT;
                end
            end
            nbgfe_pkg::ST_JWT: state_next = nbgfe_pkg::ST_DIF;
            nbgfe_pkg::ST_DIF: begin
                for (int c = 0; c < 3; c++) begin
                    d_next[c] = $signed({bp_reg[c][31], bp_reg[c]}) -
                                $signed({rd_pos[c][31], rd_pos[c]});
                end
                prod_next  = '0;
                comp_next  = 2'd0;
                state_next = nbgfe_pkg::ST_SQ;
            end
            nbgfe_pkg::ST_SQ: begin
                prod_next = prod_reg + NUM_W'(mul_p);
                if (comp_reg == 2'd2) begin
                    comp_next  = 2'd0;
                    state_next = nbgfe_pkg::ST_CLAMP;
                end else begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            nbgfe_pkg::ST_CLAMP: begin
                s_c = prod_reg[DIV_W-1:0];
                if (func_reg == nbgfe_pkg::FN_FORCE && s_c < DIV_W'({mdsq_reg, 16'h0000})) begin
                    s_c = DIV_W'({mdsq_reg, 16'h0000});
                end
                s_next = s_c;
                if (func_reg == nbgfe_pkg::FN_FORCE && s_c == '0) begin
                    // coincident bodies add nothing
                    j_next     = j_reg + CNT_W'(1);
                    state_next = nbgfe_pkg::ST_JSEL;
                end else begin
                    num_next   = {s_c, 31'h0};
                    rem_next   = '0;
                    r_next     = '0;
                    cnt_next   = nbgfe_pkg::SQRT_STEPS;
                    state_next = nbgfe_pkg::ST_SQRT;
                end
            end
            nbgfe_pkg::ST_SQRT: begin
                rem_next = rem_step;
                r_next   = {r_reg[31:0], ge};
                num_next = num_step;
                cnt_next = cnt_reg - SW'(1);
                if (step_last) begin
                    state_next = (func_reg == nbgfe_pkg::FN_FORCE) ? nbgfe_pkg::ST_K1
                                                                   : nbgfe_pkg::ST_RFIX;
                end
            end
            nbgfe_pkg::ST_RFIX: begin
                r_fix = (r_reg < 33'(md_reg)) ? 33'(md_reg) : r_reg;
                if (r_fix == '0) begin
                    r_fix = 33'd1;
                end
                r_next     = r_fix;
                state_next = nbgfe_pkg::ST_K1;
            end
            nbgfe_pkg::ST_K1: begin
                k_next     = mul_p;
                state_next = nbgfe_pkg::ST_K2;
            end
            nbgfe_pkg::ST_K2: begin
                prod_next  = NUM_W'(mul_p);
                state_next = nbgfe_pkg::ST_K3;
            end
            nbgfe_pkg::ST_K3: begin
                k_next = mul_p + 64'(prod_reg[63:32]);
                if (func_reg == nbgfe_pkg::FN_FORCE) begin
                    comp_next  = 2'd0;
                    state_next = nbgfe_pkg::ST_CSEL;
                end else begin
                    num_next   = NUM_W'({k_next, 16'h0000});
                    rem_next   = '0;
                    cnt_next   = nbgfe_pkg::DIV_STEPS;
                    state_next = nbgfe_pkg::ST_MDIV;
                end
            end
            nbgfe_pkg::ST_CSEL: begin
                if (d_sel == '0) begin
                    if (comp_reg == 2'd2) begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = nbgfe_pkg::ST_JSEL;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end else begin
                    num_next   = NUM_W'({dmag, 32'h0});
                    rem_next   = '0;
                    cnt_next   = nbgfe_pkg::DIV_STEPS;
                    state_next = nbgfe_pkg::ST_UDIV;
                end
            end
            nbgfe_pkg::ST_UDIV: begin
                rem_next = rem_step;
                num_next = num_step;
                cnt_next = cnt_reg - SW'(1);
                if (step_last) begin
                    u_next     = num_step[32:0];
                    state_next = nbgfe_pkg::ST_P1;
                end
            end
            nbgfe_pkg::ST_P1: begin
                prod_next  = NUM_W'(mul_p);
                state_next = nbgfe_pkg::ST_P2;
            end
            nbgfe_pkg::ST_P2: begin
                prod_next  = prod_reg + (NUM_W'(mul_p) << 32);
                state_next = nbgfe_pkg::ST_P3;
            end
            nbgfe_pkg::ST_P3: begin
                p_fin = prod_reg;
                if (u_reg[32]) begin
                    p_fin = prod_reg + NUM_W'({k_reg, 32'h0});
                end
                num_next   = p_fin;
                rem_next   = '0;
                cnt_next   = nbgfe_pkg::DIV_STEPS;
                state_next = nbgfe_pkg::ST_MDIV;
            end
            nbgfe_pkg::ST_MDIV: begin
                rem_next = rem_step;
                num_next = num_step;
                cnt_next = cnt_reg - SW'(1);
                if (step_last) begin
                    q_ext = ACC_W'(num_step);
                    if (func_reg == nbgfe_pkg::FN_FORCE) begin
                        // force points away from positive offset
                        for (int e = 0; e < 3; e++) begin
                            if (comp_reg == 2'(e)) begin
                                acc_next[e] = d_sel[32] ? acc_reg[e] + q_ext
                                                        : acc_reg[e] - q_ext;
                            end
                        end
                        if (comp_reg == 2'd2) begin
                            j_next     = j_reg + CNT_W'(1);
                            state_next = nbgfe_pkg::ST_JSEL;
                        end else begin
                            comp_next  = comp_reg + 2'd1;
                            state_next = nbgfe_pkg::ST_CSEL;
                        end
                    end else begin
                        // each unordered pair counts twice
                        acc_next[3] = acc_reg[3] - (q_ext << 1);
                        j_next      = j_reg + CNT_W'(1);
                        state_next  = nbgfe_pkg::ST_JSEL;
                    end
                end
            end
            nbgfe_pkg::ST_ISEL: begin
                if (i_reg == n_reg) begin
                    state_next = nbgfe_pkg::ST_DONE;
                end else begin
                    addr_next  = i_reg[IDX_W-1:0];
                    state_next = nbgfe_pkg::ST_IWT;
                end
            end
            nbgfe_pkg::ST_IWT: state_next = nbgfe_pkg::ST_ILD;
            nbgfe_pkg::ST_ILD: begin
                bp_next    = rd_pos;
                bm_next    = rd_reg.mass;
                j_next     = i_reg + CNT_W'(1);
                state_next = nbgfe_pkg::ST_JSEL;
            end
            nbgfe_pkg::ST_KSEL: begin
                if (i_reg == n_reg) begin
                    state_next = nbgfe_pkg::ST_DONE;
                end else begin
                    addr_next  = i_reg[IDX_W-1:0];
                    state_next = nbgfe_pkg::ST_KWT;
                end
            end
            nbgfe_pkg::ST_KWT: begin
                prod_next  = '0;
                comp_next  = 2'd0;
                state_next = nbgfe_pkg::ST_KV;
            end
            nbgfe_pkg::ST_KV: begin
                prod_next = prod_reg + NUM_W'(mul_p);
                if (comp_reg == 2'd2) begin
                    comp_next  = 2'd0;
                    state_next = nbgfe_pkg::ST_KM1;
                end else begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            nbgfe_pkg::ST_KM1: begin
                k_next     = prod_reg[63:0];
                prod_next  = NUM_W'(mul_p);
                state_next = nbgfe_pkg::ST_KM2;
            end
            nbgfe_pkg::ST_KM2: begin
                prod_next  = prod_reg + (NUM_W'(mul_p) << 32);
                state_next = nbgfe_pkg::ST_KACC;
            end
            nbgfe_pkg::ST_KACC: begin
                acc_next[3] = acc_reg[3] + ACC_W'(prod_reg >> 17);
                i_next      = i_reg + CNT_W'(1);
                state_next  = nbgfe_pkg::ST_KSEL;
            end
            nbgfe_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {nbgfe_pkg::sat64(acc_reg[3]), nbgfe_pkg::sat64(acc_reg[2]),
                                    nbgfe_pkg::sat64(acc_reg[1]), nbgfe_pkg::sat64(acc_reg[0])};
                    m_user_next  = status_reg;
                    state_next   = nbgfe_pkg::ST_IDLE;
                end
            end
            default: state_next = nbgfe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nbgfe_pkg::ST_IDLE;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
            grav_reg    <= 32'd1;
            mdsq_reg    <= 32'd1;
            md_reg      <= 32'd1;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    nbgfe_pkg::REG_GRAV:    grav_reg <= cfg_data;
                    nbgfe_pkg::REG_MIN_DSQ: mdsq_reg <= cfg_data;
                    nbgfe_pkg::REG_MIN_D:   md_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        id_reg     <= id_next;
        off_reg    <= off_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        addr_reg   <= addr_next;
        bp_reg     <= bp_next;
        bm_reg     <= bm_next;
        d_reg      <= d_next;
        comp_reg   <= comp_next;
        prod_reg   <= prod_next;
        s_reg      <= s_next;
        r_reg      <= r_next;
        k_reg      <= k_next;
        u_reg      <= u_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // body table
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[n_reg[IDX_W-1:0]] <= wr_body;
        end
        rd_reg <= mem[addr_reg];
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CNT_W'(nbgfe_pkg::MAX_BODIES))
        else $error("body count beyond table depth");

    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nbgfe_pkg::ST_SQRT || state_reg == nbgfe_pkg::ST_UDIV ||
         state_reg == nbgfe_pkg::ST_MDIV) |-> cnt_reg != '0)
        else $error("iteration count ran out");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == nbgfe_pkg::FN_APPEND &&
         n_reg < CNT_W'(nbgfe_pkg::MAX_BODIES)) |=> n_reg == $past(n_reg) + CNT_W'(1))
        else $error("append did not add a body");

    a_bad_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == nbgfe_pkg::FN_FORCE &&
         CMP_W'(s_tdata[9:0]) >= CMP_W'(n_reg))
        |=> state_reg == nbgfe_pkg::ST_DONE && status_reg == nbgfe_pkg::STS_NOIDX)
        else $error("unloaded index not rejected");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != nbgfe_pkg::STS_OK) |-> m_tdata == '0)
        else $error("rejected item carries data");

endmodule
